// ===== hdl/qtrra_pkg.sv =====
// Package for the quantum token round-robin arbiter.
// Holds default sizes, the quantum field width and the access status codes.
// No dependencies.
package qtrra_pkg;

  localparam int MAX_MASTERS_DEF = 8;
  localparam int ADDR_WIDTH_DEF  = 32;
  localparam int QUANTUM_W       = 32;
  localparam int STATUS_W        = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 2'd0,
    ST_ENLIST_ONLY = 2'd1,
    ST_DENIED      = 2'd2
  } status_t;

endpackage

// ===== hdl/qtrra_in_if.sv =====
// Access channel of the arbiter: valid/ready plus master id, address, quantum.
// Depends on qtrra_pkg.
interface qtrra_in_if #(
  parameter int ID_W   = $clog2(qtrra_pkg::MAX_MASTERS_DEF),
  parameter int ADDR_W = qtrra_pkg::ADDR_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [ID_W-1:0]                master_id;
  logic [ADDR_W-1:0]              raw_address;
  logic [qtrra_pkg::QUANTUM_W-1:0] quantum_index;

  modport source (output valid, master_id, raw_address, quantum_index, input ready);
  modport sink   (input valid, master_id, raw_address, quantum_index, output ready);
endinterface

// ===== hdl/qtrra_out_if.sv =====
// Result channel of the arbiter: valid/ready plus clean address, status, holder.
// Depends on qtrra_pkg.
interface qtrra_out_if #(
  parameter int ADDR_W   = qtrra_pkg::ADDR_WIDTH_DEF,
  parameter int HOLDER_W = $clog2(qtrra_pkg::MAX_MASTERS_DEF + 1)
);
  logic                   valid;
  logic                   ready;
  logic [ADDR_W-2:0]      clean_address;
  qtrra_pkg::status_t     access_status;
  logic [HOLDER_W-1:0]    token_holder;

  modport source (output valid, clean_address, access_status, token_holder, input ready);
  modport sink   (input valid, clean_address, access_status, token_holder, output ready);
endinterface

// ===== hdl/qtrra_cfg_if.sv =====
// Configuration write channel of the arbiter: valid/ready plus masters_in_use.
// Depends on qtrra_pkg.
interface qtrra_cfg_if #(
  parameter int CNT_W = $clog2(qtrra_pkg::MAX_MASTERS_DEF + 1)
);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] masters_in_use;

  modport source (output valid, masters_in_use, input ready);
  modport sink   (input valid, masters_in_use, output ready);
endinterface

// ===== hdl/quantum_token_round_robin_arbiter_unit.sv =====
// Quantum token round-robin arbiter, top level.
// An accepted access beat moves from the input register into the result register.
// Throughput: one access per cycle while out_bus is not stalled; election is a
// priority pick over the enlist marks between the input register and the result register.
// Reset (rst_n low, synchronous): marks clear, no holder, stored quantum 0,
// masters_in_use back to MAX_MASTERS, both pipeline registers empty.
module quantum_token_round_robin_arbiter_unit #(
  parameter int MAX_MASTERS = qtrra_pkg::MAX_MASTERS_DEF,
  parameter int ADDR_WIDTH  = qtrra_pkg::ADDR_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  qtrra_in_if.sink         in_bus,
  qtrra_out_if.source      out_bus,
  qtrra_cfg_if.sink        cfg_bus
);
  import qtrra_pkg::*;

  localparam int ID_W  = $clog2(MAX_MASTERS);
  localparam int CNT_W = $clog2(MAX_MASTERS + 1);
  localparam logic [CNT_W-1:0] NO_HOLDER = CNT_W'(MAX_MASTERS);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_MASTERS);

  // input register
  logic                  s1_vld_r;
  logic [ID_W-1:0]       s1_id_r;
  logic [ADDR_WIDTH-1:0] s1_addr_r;
  logic [QUANTUM_W-1:0]  s1_quant_r;

  // result register
  logic                  out_vld_r;
  logic [ADDR_WIDTH-2:0] out_addr_r;
  status_t               out_status_r;
  logic [CNT_W-1:0]      out_holder_r;

  // arbiter state
  logic [MAX_MASTERS-1:0] marks_r, marks_nxt;
  logic [CNT_W-1:0]       holder_r, holder_nxt;
  logic [QUANTUM_W-1:0]   quant_r;
  logic [CNT_W-1:0]       masters_r;

  logic                   fire;
  logic                   new_quantum;
  logic [CNT_W-1:0]       cnt_sat;
  logic [CNT_W-1:0]       start;
  logic [MAX_MASTERS-1:0] cand;
  logic                   hi_found, lo_found;
  logic [CNT_W-1:0]       hi_idx, lo_idx, elected;
  logic [CNT_W-1:0]       id_ext;
  logic [ADDR_WIDTH-2:0]  clean;
  status_t                status;

  assign fire          = s1_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready  = !s1_vld_r || fire;
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid         = out_vld_r;
  assign out_bus.clean_address = out_addr_r;
  assign out_bus.access_status = out_status_r;
  assign out_bus.token_holder  = out_holder_r;

  // election over masters below the saturated count, starting after the holder
  always_comb begin
    cnt_sat = (masters_r > MAX_CNT) ? MAX_CNT : masters_r;
    start   = (holder_r < cnt_sat) ? holder_r + CNT_W'(1) : '0;
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int i = MAX_MASTERS - 1; i >= 0; i--) begin
      cand[i] = marks_r[i] && (CNT_W'(i) < cnt_sat);
      if (cand[i] && CNT_W'(i) >= start) begin
        hi_found = 1'b1;
        hi_idx   = CNT_W'(i);
      end
      if (cand[i]) begin
        lo_found = 1'b1;
        lo_idx   = CNT_W'(i);
      end
    end
    if (hi_found) begin
      elected = hi_idx;
    end else if (lo_found) begin
      elected = lo_idx;
    end else begin
      elected = NO_HOLDER;
    end
  end

  always_comb begin
    new_quantum = (s1_quant_r != quant_r);
    id_ext      = CNT_W'(s1_id_r);
    holder_nxt  = new_quantum ? elected : holder_r;
    marks_nxt   = new_quantum ? '0 : marks_r;
    if (s1_addr_r[ADDR_WIDTH-1] && id_ext < MAX_CNT) begin
      marks_nxt[s1_id_r] = 1'b1;
    end
    clean = s1_addr_r[ADDR_WIDTH-2:0];
    if (clean == '1) begin
      status = ST_ENLIST_ONLY;
    end else if (holder_nxt != NO_HOLDER && id_ext == holder_nxt) begin
      status = ST_GRANTED;
    end else begin
      status = ST_DENIED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      marks_r   <= '0;
      holder_r  <= NO_HOLDER;
      quant_r   <= '0;
      masters_r <= MAX_CNT;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        s1_vld_r <= 1'b1;
      end else if (fire) begin
        s1_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end
      // advance state only when the beat moves into the result register
      if (fire) begin
        marks_r  <= marks_nxt;
        holder_r <= holder_nxt;
        quant_r  <= s1_quant_r;
      end
      if (cfg_bus.valid) begin
        masters_r <= cfg_bus.masters_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_id_r    <= in_bus.master_id;
      s1_addr_r  <= in_bus.raw_address;
      s1_quant_r <= in_bus.quantum_index;
    end
    if (fire) begin
      out_addr_r   <= clean;
      out_status_r <= status;
      out_holder_r <= holder_nxt;
    end
  end

endmodule
